// ===== rtl/timed_phrase_step_sequencer_top_macros.svh =====
// Assertion helpers for the sequencer top.
`ifndef TIMED_PHRASE_STEP_SEQUENCER_TOP_MACROS_SVH
`define TIMED_PHRASE_STEP_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPSS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TPSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tpss_pkg.sv =====
package tpss_pkg;

  // Default table dimensions
  localparam int MAX_PHRASES_DEF = 16;
  localparam int MAX_STEPS_DEF   = 16;

  // Input modes
  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_TRIG  = 3'd1;
  localparam logic [2:0] MODE_STOP  = 3'd2;
  localparam logic [2:0] MODE_WSTEP = 3'd3;
  localparam logic [2:0] MODE_WLEN  = 3'd4;

  // Result kinds
  localparam logic [2:0] KIND_ACTION    = 3'd0;
  localparam logic [2:0] KIND_COMPLETE  = 3'd1;
  localparam logic [2:0] KIND_TICK_DONE = 3'd2;
  localparam logic [2:0] KIND_STARTED   = 3'd3;
  localparam logic [2:0] KIND_REJECTED  = 3'd4;
  localparam logic [2:0] KIND_ACK       = 3'd5;

  // Phrase count register
  typedef logic [4:0] count_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  phrase_sel;
    logic [3:0]  step_sel;
    logic [4:0]  length_in;
    logic [15:0] position_in;
    logic [7:0]  action_in;
    logic [7:0]  param_in;
    logic [15:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  phrase_out;
    logic [7:0]  action_out;
    logic [7:0]  param_out;
    logic [15:0] value_out;
    logic        active;
    logic        last;
  } out_item_t;

  // One step table entry
  typedef struct packed {
    logic [15:0] position;
    logic [7:0]  action;
    logic [7:0]  param;
    logic [15:0] value;
  } step_t;

  // Datapath operation requested by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SCAN,
    OP_ACT,
    OP_CLOSE,
    OP_SINGLE
  } dp_op_t;

  typedef struct packed {
    logic   capture;
    dp_op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_start;
    logic scan_fire;
    logic act_more;
  } dp_stat_t;

endpackage

// ===== rtl/timed_phrase_step_sequencer_top.sv =====
// Commands, triggers and idle ticks give one result, formed in S_SINGLE and registered in
// the output register; no new transaction is taken until that result has been loaded.
// A tick while playing that fires k steps walks the table in S_SCAN, reading it once per cycle,
// then k actions and a closing result go out one a cycle while out_stall is low.
// Reset (rst_n low, synchronous) clears playback, phrase lengths and the trigger limit;
// the step table is not cleared and needs no clearing pass.
`include "timed_phrase_step_sequencer_top_macros.svh"

module timed_phrase_step_sequencer_top #(
  parameter int MAX_PHRASES = tpss_pkg::MAX_PHRASES_DEF,
  parameter int MAX_STEPS   = tpss_pkg::MAX_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tpss_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tpss_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  tpss_pkg::count_t    cfg_wdata
);
  import tpss_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Sequencing control
  tpss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Tables, playback state and output register
  tpss_dp #(
    .MAX_PHRASES (MAX_PHRASES),
    .MAX_STEPS   (MAX_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // One transaction in flight at a time
  `TPSS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted back to back")
  // No new transaction while a non-final result is pending
  `TPSS_ASSERT_IMPL(a_hold_mid_burst, out_valid && !out_data.last, in_stall, "accept mid burst")
  // Only defined result kinds leave the block
  `TPSS_ASSERT_IMPL(a_kind_range, out_valid, out_data.kind <= KIND_ACK, "bad result kind")

endmodule

// ===== rtl/tpss_ctrl.sv =====
module tpss_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tpss_pkg::dp_stat_t stat,
  output tpss_pkg::ctl_cmd_t cmd
);
  import tpss_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_EMIT   = 4'b0100,
    S_SINGLE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and datapath commands
  always_comb begin
    state_nxt   = state_r;
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.op      = OP_NONE;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = stat.scan_start ? S_SCAN : S_SINGLE;
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (!stat.scan_fire) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.act_more) begin
          cmd.op = OP_ACT;
        end else begin
          cmd.op = OP_CLOSE;
          if (stat.out_free) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SINGLE: begin
        cmd.op = OP_SINGLE;
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/tpss_dp.sv =====
module tpss_dp #(
  parameter int MAX_PHRASES = tpss_pkg::MAX_PHRASES_DEF,
  parameter int MAX_STEPS   = tpss_pkg::MAX_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tpss_pkg::in_item_t  in_data,
  input  logic                cfg_we,
  input  tpss_pkg::count_t    cfg_wdata,
  input  tpss_pkg::ctl_cmd_t  cmd,
  output tpss_pkg::dp_stat_t  stat,
  input  logic                out_stall,
  output logic                out_valid,
  output tpss_pkg::out_item_t out_data
);
  import tpss_pkg::*;

  localparam int PW = (MAX_PHRASES > 1) ? $clog2(MAX_PHRASES) : 1;
  localparam int SW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int CW = $clog2(MAX_STEPS + 1);

  // Table storage
  logic [CW-1:0] len_r [MAX_PHRASES];
  step_t         mem   [MAX_PHRASES][MAX_STEPS];

  // Playback and configuration state
  count_t        trig_limit_r;
  logic          playing_r;
  logic [3:0]    playing_phrase_r;
  logic [CW-1:0] next_step_r;
  logic [15:0]   row_r;

  // Per-transaction working registers
  in_item_t      cmd_r;
  logic [CW-1:0] plen_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] end_r;
  logic          done_r;
  step_t         rdata_r;

  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r;

  logic          out_free;
  logic          fire;
  logic          ps_ok, ss_ok, trig_ok;
  logic [CW-1:0] len_sat;
  logic [3:0]    len_sel;
  logic          load;
  logic          close_go, single_go;
  out_item_t     res;

  assign out_free  = !out_valid_r || !out_stall;
  assign fire      = (idx_r < plen_r) && (rdata_r.position <= row_r);
  assign ps_ok     = int'(cmd_r.phrase_sel) < MAX_PHRASES;
  assign ss_ok     = int'(cmd_r.step_sel) < MAX_STEPS;
  assign trig_ok   = ({1'b0, cmd_r.phrase_sel} < trig_limit_r) && ps_ok
                     && (plen_r != '0);
  assign len_sat   = (int'(cmd_r.length_in) > MAX_STEPS) ? CW'(MAX_STEPS)
                                                         : CW'(cmd_r.length_in);
  assign len_sel   = (in_data.mode == MODE_TRIG) ? in_data.phrase_sel
                                                 : playing_phrase_r;
  assign close_go  = (cmd.op == OP_CLOSE) && out_free;
  assign single_go = (cmd.op == OP_SINGLE) && out_free;

  assign stat.out_free   = out_free;
  assign stat.scan_start = (in_data.mode == MODE_TICK) && playing_r;
  assign stat.scan_fire  = fire;
  assign stat.act_more   = idx_r < end_r;

  // Step walk counter; the table is read at its next value so that
  // rdata_r always holds the entry at idx_r
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.capture) begin
      idx_nxt = next_step_r;
    end else if (cmd.op == OP_SCAN) begin
      idx_nxt = fire ? idx_r + 1'b1 : next_step_r;
    end else if ((cmd.op == OP_ACT) && out_free) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  // Result assembly
  always_comb begin
    res  = '0;
    load = 1'b0;
    case (cmd.op)
      OP_ACT: begin
        load           = out_free;
        res.kind       = KIND_ACTION;
        res.phrase_out = playing_phrase_r;
        res.action_out = rdata_r.action;
        res.param_out  = rdata_r.param;
        res.value_out  = rdata_r.value;
        res.active     = !done_r;
      end
      OP_CLOSE: begin
        load       = out_free;
        res.active = !done_r;
        res.last   = 1'b1;
        if (done_r && (row_r != '0)) begin
          res.kind       = KIND_COMPLETE;
          res.phrase_out = playing_phrase_r;
        end else begin
          res.kind = KIND_TICK_DONE;
        end
      end
      OP_SINGLE: begin
        load       = out_free;
        res.last   = 1'b1;
        res.active = playing_r;
        case (cmd_r.mode)
          MODE_TICK: begin
            res.kind = KIND_TICK_DONE;
          end
          MODE_TRIG: begin
            res.phrase_out = cmd_r.phrase_sel;
            res.kind       = trig_ok ? KIND_STARTED : KIND_REJECTED;
            res.active     = trig_ok || playing_r;
          end
          MODE_STOP: begin
            res.kind   = KIND_ACK;
            res.active = 1'b0;
          end
          default: begin
            res.kind = KIND_ACK;
          end
        endcase
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_limit_r     <= '0;
      playing_r        <= 1'b0;
      playing_phrase_r <= '0;
      next_step_r      <= '0;
      row_r            <= '0;
      idx_r            <= '0;
      end_r            <= '0;
      done_r           <= 1'b0;
      out_valid_r      <= 1'b0;
      for (int i = 0; i < MAX_PHRASES; i++) begin
        len_r[i] <= '0;
      end
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        trig_limit_r <= cfg_wdata;
      end
      // End of the step walk: remember where it stopped
      if ((cmd.op == OP_SCAN) && !fire) begin
        end_r  <= idx_r;
        done_r <= !(idx_r < plen_r);
      end
      // Closing result of a tick updates playback
      if (close_go) begin
        next_step_r <= end_r;
        if (done_r) begin
          playing_r <= 1'b0;
        end else if (row_r != 16'hFFFF) begin
          row_r <= row_r + 16'd1;
        end
      end
      // Single-result commands
      if (single_go) begin
        case (cmd_r.mode)
          MODE_TRIG: begin
            if (trig_ok) begin
              playing_r        <= 1'b1;
              playing_phrase_r <= cmd_r.phrase_sel;
              next_step_r      <= '0;
              row_r            <= '0;
            end
          end
          MODE_STOP: begin
            playing_r        <= 1'b0;
            playing_phrase_r <= '0;
            next_step_r      <= '0;
            row_r            <= '0;
          end
          MODE_WLEN: begin
            if (ps_ok) begin
              len_r[PW'(cmd_r.phrase_sel)] <= len_sat;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Captured transaction and phrase length
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_data;
      plen_r <= len_r[PW'(len_sel)];
    end
    if (load) begin
      out_data_r <= res;
    end
  end

  // Step table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (single_go && (cmd_r.mode == MODE_WSTEP) && ps_ok && ss_ok) begin
      mem[PW'(cmd_r.phrase_sel)][SW'(cmd_r.step_sel)] <=
        {cmd_r.position_in, cmd_r.action_in, cmd_r.param_in, cmd_r.value_in};
    end
    rdata_r <= mem[PW'(playing_phrase_r)][SW'(idx_nxt)];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== verif/tpss_sequencer_checker.sv =====
// Watches both channels and the phrase count port, predicts every result of
// each accepted transaction and compares it with what the sequencer sends.
module tpss_sequencer_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  tpss_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  tpss_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  tpss_pkg::count_t    cfg_wdata,
  output int                  mismatches,
  output int                  pending_results
);
  import tpss_pkg::*;

  localparam int PHRASES = MAX_PHRASES_DEF;
  localparam int STEPS   = MAX_STEPS_DEF;

  // Predicted sequencer state
  step_t      step_mem   [PHRASES][STEPS];
  logic [4:0] phrase_len [PHRASES];
  logic       playing;
  logic [3:0] cur_phrase;
  logic [4:0] step_idx;
  logic [15:0] row_pos;
  count_t     trig_limit;

  // Results still owed by the sequencer, oldest first
  out_item_t  due_results [$];

  function automatic out_item_t make_result(logic [2:0] kind, logic [3:0] ph, step_t st);
    out_item_t r;
    r.kind       = kind;
    r.phrase_out = ph;
    r.action_out = st.action;
    r.param_out  = st.param;
    r.value_out  = st.value;
    r.active     = 1'b0;
    r.last       = 1'b0;
    return r;
  endfunction

  task automatic report(string field, logic [15:0] got, logic [15:0] want);
    $display("tpss mismatch: %s got %0h expected %0h at %0t", field, got, want, $time);
    mismatches++;
  endtask

  // Work out all results of one transaction and queue them
  task automatic predict_results(in_item_t it);
    out_item_t res [$];
    step_t     st;
    logic [4:0] plen;
    case (it.mode)
      MODE_TICK: begin
        if (!playing) begin
          res.push_back(make_result(KIND_TICK_DONE, '0, '0));
        end else begin
          plen = phrase_len[cur_phrase];
          // fire every pending step that is due at this row
          while (step_idx < plen) begin
            st = step_mem[cur_phrase][step_idx[3:0]];
            if (st.position > row_pos) break;
            res.push_back(make_result(KIND_ACTION, cur_phrase, st));
            step_idx++;
          end
          if (step_idx >= plen) begin
            playing = 1'b0;
            // a phrase that ends at row zero only reports tick done
            if (row_pos != '0) res.push_back(make_result(KIND_COMPLETE, cur_phrase, '0));
            else res.push_back(make_result(KIND_TICK_DONE, '0, '0));
          end else begin
            if (row_pos != 16'hFFFF) row_pos++;
            res.push_back(make_result(KIND_TICK_DONE, '0, '0));
          end
        end
      end
      MODE_TRIG: begin
        if ({1'b0, it.phrase_sel} >= trig_limit || phrase_len[it.phrase_sel] == '0) begin
          res.push_back(make_result(KIND_REJECTED, it.phrase_sel, '0));
        end else begin
          playing    = 1'b1;
          cur_phrase = it.phrase_sel;
          step_idx   = '0;
          row_pos    = '0;
          res.push_back(make_result(KIND_STARTED, it.phrase_sel, '0));
        end
      end
      default: begin
        if (it.mode == MODE_STOP) begin
          playing    = 1'b0;
          cur_phrase = '0;
          step_idx   = '0;
          row_pos    = '0;
        end else if (it.mode == MODE_WSTEP) begin
          step_mem[it.phrase_sel][it.step_sel] =
            {it.position_in, it.action_in, it.param_in, it.value_in};
        end else if (it.mode == MODE_WLEN) begin
          // lengths above the table depth saturate
          phrase_len[it.phrase_sel] = (it.length_in > STEPS) ? 5'(STEPS) : it.length_in;
        end
        // undefined modes only get the acknowledge
        res.push_back(make_result(KIND_ACK, '0, '0));
      end
    endcase
    foreach (res[i]) begin
      res[i].active = playing;
      res[i].last   = (i == res.size() - 1);
      due_results.push_back(res[i]);
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (due_results.size() == 0) begin
      report("result with nothing due, kind", got.kind, '0);
      return;
    end
    want = due_results.pop_front();
    if (got.kind !== want.kind)             report("kind", got.kind, want.kind);
    if (got.phrase_out !== want.phrase_out) report("phrase_out", got.phrase_out, want.phrase_out);
    if (got.action_out !== want.action_out) report("action_out", got.action_out, want.action_out);
    if (got.param_out !== want.param_out)   report("param_out", got.param_out, want.param_out);
    if (got.value_out !== want.value_out)   report("value_out", got.value_out, want.value_out);
    if (got.active !== want.active)         report("active", got.active, want.active);
    if (got.last !== want.last)             report("last", got.last, want.last);
  endtask

  // Results are compared before new transactions are predicted: no transaction
  // can produce a result at the edge where it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      playing      = 1'b0;
      cur_phrase   = '0;
      step_idx     = '0;
      row_pos      = '0;
      trig_limit   = '0;
      foreach (phrase_len[i]) phrase_len[i] = '0;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (cfg_we) trig_limit = cfg_wdata;
      if (in_valid && !in_stall) predict_results(in_data);
    end
    pending_results = due_results.size();
  end

endmodule

// ===== verif/tb_timed_phrase_step_sequencer_top.sv =====
module tb_timed_phrase_step_sequencer_top;
  import tpss_pkg::*;

  localparam int PHRASES     = MAX_PHRASES_DEF;
  localparam int STEPS       = MAX_STEPS_DEF;
  localparam int IDLE_PCT    = 6;
  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE      = 40;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we    = 1'b0;
  count_t    cfg_wdata = '0;

  int        mismatches;
  int        pending_results;
  bit        calm       = 1'b0;
  int        items_sent = 0;
  int        idle_run   = 0;
  count_t    cur_count  = '0;
  // steps written so far, per phrase: lengths never reach an unwritten step
  logic [15:0] written [PHRASES];

  always #4 clk = ~clk;

  timed_phrase_step_sequencer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  tpss_sequencer_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .pending_results (pending_results)
  );

  // Result side back-pressure
  always @(negedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog: cycles in a row with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run <= 0;
    end else if (idle_run == STALL_LIMIT) begin
      $display("tb_timed_phrase_step_sequencer_top NOT OK");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // Present one transaction, with an occasional gap ahead of it
  task automatic send(in_item_t it);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // Unused fields carry random bits
  function automatic in_item_t noise_item(logic [2:0] mode, logic [3:0] ph);
    in_item_t it;
    it            = in_item_t'({$urandom, $urandom});
    it.mode       = mode;
    it.phrase_sel = ph;
    return it;
  endfunction

  task automatic send_op(logic [2:0] mode, logic [3:0] ph);
    send(noise_item(mode, ph));
  endtask

  task automatic write_step(logic [3:0] ph, logic [3:0] st, logic [15:0] pos,
                            logic [7:0] act, logic [7:0] par, logic [15:0] val);
    in_item_t it;
    it             = noise_item(MODE_WSTEP, ph);
    it.step_sel    = st;
    it.position_in = pos;
    it.action_in   = act;
    it.param_in    = par;
    it.value_in    = val;
    written[ph][st] = 1'b1;
    send(it);
  endtask

  task automatic write_length(logic [3:0] ph, logic [4:0] len);
    in_item_t it;
    it           = noise_item(MODE_WLEN, ph);
    it.length_in = len;
    send(it);
  endtask

  function automatic int written_prefix(logic [3:0] ph);
    int n;
    n = 0;
    while (n < STEPS && written[ph][n]) n++;
    return n;
  endfunction

  // Any length that only covers written steps
  function automatic logic [4:0] legal_length(logic [3:0] ph);
    int pre;
    pre = written_prefix(ph);
    if (pre == STEPS) return 5'($urandom_range(31, 0));
    return 5'($urandom_range(pre, 0));
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic set_phrase_count(count_t v);
    drain();
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_count  = v;
  endtask

  task automatic random_noise();
    logic [3:0] ph;
    ph = 4'($urandom);
    case ($urandom_range(5))
      0: send_op(MODE_TICK, ph);
      1: send_op(MODE_TRIG, ph);
      2: send_op(MODE_STOP, ph);
      3: send_op(3'($urandom_range(7, int'(MODE_WLEN) + 1)), ph);
      4: write_length(ph, legal_length(ph));
      default: write_step(ph, 4'($urandom), 16'($urandom), 8'($urandom),
                          8'($urandom), 16'($urandom));
    endcase
  endtask

  // Program a phrase, trigger it and tick through it, with some disturbance
  task automatic phrase_run();
    logic [3:0] ph;
    int nsteps;
    int pos;
    int nticks;
    ph = (cur_count != 0 && $urandom_range(99) < 85) ?
         4'($urandom_range(cur_count - 1)) : 4'($urandom);
    nsteps = ($urandom_range(99) < 12) ? STEPS : $urandom_range(6, 1);
    pos = 8;
    if (written_prefix(ph) < nsteps || $urandom_range(99) < 70) begin
      pos = 0;
      for (int s = 0; s < nsteps; s++) begin
        pos += $urandom_range(3);
        if ($urandom_range(99) < 4) pos = $urandom_range(65535, pos);
        write_step(ph, 4'(s), 16'(pos), 8'($urandom), 8'($urandom), 16'($urandom));
      end
    end
    if (nsteps == STEPS) write_length(ph, 5'($urandom_range(31, STEPS)));
    else if ($urandom_range(99) < 15) write_length(ph, 5'($urandom_range(nsteps, 0)));
    else write_length(ph, 5'(nsteps));
    send_op(MODE_TRIG, ph);
    nticks = (pos > 30 ? 30 : pos) + $urandom_range(3, 1);
    repeat (nticks) begin
      if ($urandom_range(99) < 6) begin
        case ($urandom_range(3))
          0: write_length(ph, legal_length(ph));
          1: send_op(MODE_STOP, 4'($urandom));
          2: send_op(MODE_TRIG, ph);
          default: random_noise();
        endcase
      end else begin
        send_op(MODE_TICK, 4'($urandom));
      end
    end
    // let the sequencer run dry now and then
    if ($urandom_range(99) < 15) drain();
  endtask

  task automatic run_phase(count_t v, int quota);
    int stop_at;
    set_phrase_count(v);
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 85) phrase_run();
      else repeat ($urandom_range(4, 1)) random_noise();
    end
  endtask

  initial begin
    foreach (written[i]) written[i] = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Idle tick, trigger with no phrases allowed, undefined modes, stop
    send_op(MODE_TICK, 4'h0);
    send_op(MODE_TRIG, 4'h0);
    for (int m = int'(MODE_WLEN) + 1; m < 8; m++) send_op(3'(m), 4'hF);
    send_op(MODE_STOP, 4'h0);
    set_phrase_count(5'(PHRASES));

    // Empty phrase is rejected; steps all at row zero end with tick done
    send_op(MODE_TRIG, 4'hF);
    write_step(4'hF, 4'd0, 16'h0000, 8'hFF, 8'hFF, 16'hFFFF);
    write_step(4'hF, 4'd1, 16'h0000, 8'h00, 8'h00, 16'h0000);
    write_length(4'hF, 5'd2);
    send_op(MODE_TRIG, 4'hF);
    send_op(MODE_TICK, 4'h0);

    // Length cut while playing ends the phrase with a completion
    write_step(4'd3, 4'd0, 16'd1, 8'h5A, 8'hA5, 16'h1234);
    write_step(4'd3, 4'd1, 16'hFFFF, 8'hC3, 8'h3C, 16'hFEDC);
    write_length(4'd3, 5'd2);
    send_op(MODE_TRIG, 4'd3);
    send_op(MODE_TICK, 4'h0);
    send_op(MODE_TICK, 4'h0);
    write_length(4'd3, 5'd1);
    send_op(MODE_TICK, 4'h0);

    // Stop cancels playback
    send_op(MODE_TRIG, 4'd3);
    send_op(MODE_STOP, 4'h0);
    send_op(MODE_TICK, 4'h0);

    run_phase(5'd16, 70);
    run_phase(5'd1, 50);
    calm = 1'b1;
    run_phase(5'd15, 65);
    calm = 1'b0;
    run_phase(5'd0, 25);
    run_phase(5'($urandom_range(14, 2)), 65);
    run_phase(5'd16, 75);

    drain();
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_timed_phrase_step_sequencer_top OK");
    end else begin
      $display("tb_timed_phrase_step_sequencer_top NOT OK");
    end
    $finish;
  end

endmodule
